/* sv/tsc_pkg.sv */
// shared types and constants of the taylor sine / cosine unit
package tsc_pkg;

   localparam int ANGLE_W    = 32;
   localparam int VALUE_W    = 40;
   localparam int TERMS_W    = 5;
   localparam int EPS_W      = 29;
   localparam int FRAC_W     = 28;
   localparam int X2_W       = 35;
   localparam int MAG_W      = 40;
   localparam int OPER_W     = 32;
   localparam int PROD_W     = 2 * OPER_W;
   localparam int ACC_W      = 76;
   localparam int QUO_W      = ACC_W - FRAC_W;
   localparam int K_W        = 7;
   localparam int DEN_W      = 13;
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = QUO_W / DIV_STEP;
   localparam int PHASE_W    = 4;
   localparam int MUL_PARTS  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_MODE_COSINE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EPSILON     = 1'b1;

   localparam logic [EPS_W-1:0] EPS_RESET  = 29'd26843546;
   localparam logic [MAG_W-1:0] ONE_Q28    = 40'd268435456;
   localparam logic [FRAC_W-1:0] HALF_Q28  = 28'd134217728;

   typedef enum logic [2:0] {
      MUL_SQUARE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_HH
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        x2_load;
      logic        acc_en;
      logic        acc_first;
      mul_sel_type acc_sel;
      logic        div_en;
      logic        div_first;
      logic        update;
      logic        set_capped;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic ge_eps;
      logic at_cap;
   } status_type;

endpackage

/* sv/tsc_req_if.sv */
// request channel carrying one angle per transaction
interface tsc_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsc_pkg::ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);
endinterface

/* sv/tsc_rsp_if.sv */
// response channel carrying one series result per transaction
interface tsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsc_pkg::VALUE_W-1:0] value;
   logic        [tsc_pkg::TERMS_W-1:0] terms_added;
   logic                               capped;

   modport source (output valid, output value, output terms_added, output capped, input ready);
   modport sink (input valid, input value, input terms_added, input capped, output ready);
endinterface

/* sv/taylor_sine_cosine_unit.sv */
// taylor series sine / cosine unit: csr block, controller and datapath
// each term: products on the shared 32x32 multiplier, then the 4-bit-per-cycle divider
// one transaction at a time, up to MAX_TERMS terms added; a new request is taken only in idle
// reset: synchronous active high, clears control, mode_cosine to 0, epsilon to about 0.1
module taylor_sine_cosine_unit #(
   parameter int MAX_TERMS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   tsc_req_if.sink                            req_chan,
   tsc_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tsc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tsc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic                          mode_cosine_ff, mode_cosine_in;
   logic [tsc_pkg::EPS_W-1:0]     epsilon_ff, epsilon_in;
   logic [tsc_pkg::CSR_IDX_W-1:0] csr_index;
   logic                          csr_write;
   tsc_pkg::cmd_type              cmd;
   tsc_pkg::status_type           status;

   assign pready    = 1'b1;
   assign csr_index = paddr[2 +: tsc_pkg::CSR_IDX_W];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_cosine_in = mode_cosine_ff;
      epsilon_in     = epsilon_ff;
      if (csr_write) begin
         case (csr_index)
            tsc_pkg::REG_MODE_COSINE: mode_cosine_in = pwdata[0];
            tsc_pkg::REG_EPSILON:     epsilon_in     = pwdata[tsc_pkg::EPS_W-1:0];
            default: begin
               mode_cosine_in = mode_cosine_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tsc_pkg::REG_MODE_COSINE: prdata = tsc_pkg::CSR_DATA_W'(mode_cosine_ff);
         tsc_pkg::REG_EPSILON:     prdata = tsc_pkg::CSR_DATA_W'(epsilon_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_cosine_ff <= 1'b0;
         epsilon_ff     <= tsc_pkg::EPS_RESET;
      end else begin
         mode_cosine_ff <= mode_cosine_in;
         epsilon_ff     <= epsilon_in;
      end
   end

   tsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsc_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .mode_cosine     (mode_cosine_ff),
      .epsilon         (epsilon_ff),
      .req_angle       (req_chan.angle),
      .rsp_value       (rsp_chan.value),
      .rsp_terms_added (rsp_chan.terms_added),
      .rsp_capped      (rsp_chan.capped)
   );

endmodule

/* sv/tsc_controller.sv */
// state machine sequencing square, term product, division and sum update
module tsc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tsc_pkg::status_type status,
   output tsc_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SQUARE = 8'b0000_0010,
      ST_ROUND  = 8'b0000_0100,
      ST_CHECK  = 8'b0000_1000,
      ST_MULT   = 8'b0001_0000,
      ST_DIVIDE = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   localparam logic [tsc_pkg::PHASE_W-1:0] PH_MUL_LAST =
      tsc_pkg::PHASE_W'(tsc_pkg::MUL_PARTS);
   localparam logic [tsc_pkg::PHASE_W-1:0] PH_DIV_LAST =
      tsc_pkg::PHASE_W'(tsc_pkg::DIV_CYCLES - 1);

   state_type                     state_ff, state_in;
   logic [tsc_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tsc_pkg::MUL_SQUARE;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.x2_load = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.ge_eps) begin
               state_in = ST_FINISH;
            end else if (status.at_cap) begin
               cmd.set_capped = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               phase_in = '0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            case (phase_ff)
               tsc_pkg::PHASE_W'(0): begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = tsc_pkg::MUL_LL;
               end
               tsc_pkg::PHASE_W'(1): begin
                  cmd.mul_en    = 1'b1;
                  cmd.mul_sel   = tsc_pkg::MUL_LH;
                  cmd.acc_en    = 1'b1;
                  cmd.acc_first = 1'b1;
                  cmd.acc_sel   = tsc_pkg::MUL_LL;
               end
               tsc_pkg::PHASE_W'(2): begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = tsc_pkg::MUL_HL;
                  cmd.acc_en  = 1'b1;
                  cmd.acc_sel = tsc_pkg::MUL_LH;
               end
               tsc_pkg::PHASE_W'(3): begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = tsc_pkg::MUL_HH;
                  cmd.acc_en  = 1'b1;
                  cmd.acc_sel = tsc_pkg::MUL_HL;
               end
               default: begin
                  cmd.acc_en  = 1'b1;
                  cmd.acc_sel = tsc_pkg::MUL_HH;
               end
            endcase
            if (phase_ff == PH_MUL_LAST) begin
               phase_in = '0;
               state_in = ST_DIVIDE;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_en    = 1'b1;
            cmd.div_first = (phase_ff == '0);
            if (phase_ff == PH_DIV_LAST) begin
               state_in = ST_UPDATE;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts_square: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SQUARE))
      else $error("accepted transaction did not start the square step");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_divide_ends_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && phase_ff == PH_DIV_LAST) |=> (state_ff == ST_UPDATE))
      else $error("division did not end in the update step");
`endif

endmodule

/* sv/tsc_datapath.sv */
// shared multiplier, term accumulator, radix-16 divider and saturating sum
module tsc_datapath #(
   parameter int MAX_TERMS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tsc_pkg::cmd_type                   cmd,
   output tsc_pkg::status_type                status,
   input  logic                               mode_cosine,
   input  logic        [tsc_pkg::EPS_W-1:0]   epsilon,
   input  logic signed [tsc_pkg::ANGLE_W-1:0] req_angle,
   output logic signed [tsc_pkg::VALUE_W-1:0] rsp_value,
   output logic        [tsc_pkg::TERMS_W-1:0] rsp_terms_added,
   output logic                               rsp_capped
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int SUM_W = tsc_pkg::VALUE_W + 2;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd549755813887);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd549755813888);

   logic        [tsc_pkg::ANGLE_W-1:0] ax_ff;
   logic        [tsc_pkg::MAG_W-1:0]   mag_ff;
   logic                               neg_ff;
   logic signed [tsc_pkg::VALUE_W-1:0] sum_ff;
   logic        [CNT_W-1:0]            count_ff;
   logic                               capped_ff;
   logic        [tsc_pkg::X2_W-1:0]    x2_ff;
   logic        [tsc_pkg::PROD_W-1:0]  prod_ff;
   logic        [tsc_pkg::ACC_W-1:0]   acc_ff;
   logic        [tsc_pkg::DEN_W-1:0]   den_ff;
   logic        [tsc_pkg::DEN_W-1:0]   rem_ff;
   logic        [tsc_pkg::QUO_W-1:0]   quo_ff;
   logic signed [tsc_pkg::VALUE_W-1:0] out_value_ff;
   logic        [tsc_pkg::TERMS_W-1:0] out_terms_ff;
   logic                               out_capped_ff;

   logic        [tsc_pkg::ANGLE_W-1:0] abs_angle;
   logic        [tsc_pkg::MAG_W-1:0]   init_mag;
   logic                               init_neg;
   logic signed [tsc_pkg::VALUE_W-1:0] init_sum;
   logic        [tsc_pkg::OPER_W-1:0]  mul_a, mul_b;
   logic        [tsc_pkg::PROD_W-1:0]  prod_in;
   logic        [tsc_pkg::ACC_W-1:0]   acc_base, acc_term, acc_in;
   logic        [tsc_pkg::K_W-1:0]     k_half, k_val, k_next;
   logic        [tsc_pkg::DEN_W-1:0]   den_in;
   logic        [tsc_pkg::DEN_W-1:0]   rem_in;
   logic        [tsc_pkg::QUO_W-1:0]   quo_in;
   logic        [tsc_pkg::MAG_W-1:0]   new_mag;
   logic                               new_neg;
   logic signed [SUM_W-1:0]            sum_wide, mag_wide, sum_raw;
   logic signed [tsc_pkg::VALUE_W-1:0] new_sum;
   logic        [31:0]                 count_wide;
   logic        [tsc_pkg::TERMS_W-1:0] terms_sat;

   // initial term from the angle
   always_comb begin
      abs_angle = req_angle[tsc_pkg::ANGLE_W-1] ? (~req_angle + 1'b1) : req_angle;
      if (mode_cosine) begin
         init_mag = tsc_pkg::ONE_Q28;
         init_neg = 1'b0;
         init_sum = tsc_pkg::ONE_Q28;
      end else begin
         init_mag = tsc_pkg::MAG_W'(abs_angle);
         init_neg = req_angle[tsc_pkg::ANGLE_W-1];
         init_sum = init_neg ? -tsc_pkg::VALUE_W'(abs_angle)
                             : tsc_pkg::VALUE_W'(abs_angle);
      end
   end

   // shared 32x32 multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         tsc_pkg::MUL_SQUARE: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         tsc_pkg::MUL_LL: begin
            mul_a = mag_ff[31:0];
            mul_b = x2_ff[31:0];
         end
         tsc_pkg::MUL_LH: begin
            mul_a = mag_ff[31:0];
            mul_b = tsc_pkg::OPER_W'(x2_ff[tsc_pkg::X2_W-1:32]);
         end
         tsc_pkg::MUL_HL: begin
            mul_a = tsc_pkg::OPER_W'(mag_ff[tsc_pkg::MAG_W-1:32]);
            mul_b = x2_ff[31:0];
         end
         tsc_pkg::MUL_HH: begin
            mul_a = tsc_pkg::OPER_W'(mag_ff[tsc_pkg::MAG_W-1:32]);
            mul_b = tsc_pkg::OPER_W'(x2_ff[tsc_pkg::X2_W-1:32]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = tsc_pkg::PROD_W'(mul_a) * tsc_pkg::PROD_W'(mul_b);
   end

   // accumulator starts with the rounding half and half the divisor
   always_comb begin
      if (cmd.acc_first) begin
         acc_base = tsc_pkg::ACC_W'(tsc_pkg::HALF_Q28)
                  | (tsc_pkg::ACC_W'(den_ff >> 1) << tsc_pkg::FRAC_W);
      end else begin
         acc_base = acc_ff;
      end
      case (cmd.acc_sel)
         tsc_pkg::MUL_LL: acc_term = tsc_pkg::ACC_W'(prod_ff);
         tsc_pkg::MUL_LH: acc_term = tsc_pkg::ACC_W'(prod_ff) << 32;
         tsc_pkg::MUL_HL: acc_term = tsc_pkg::ACC_W'(prod_ff) << 32;
         tsc_pkg::MUL_HH: acc_term = tsc_pkg::ACC_W'(prod_ff) << 64;
         default:         acc_term = '0;
      endcase
      acc_in = acc_base + acc_term;
   end

   // divisor k * (k + 1)
   always_comb begin
      k_half = tsc_pkg::K_W'(count_ff) + 1'b1;
      k_val  = (k_half << 1) - tsc_pkg::K_W'(mode_cosine);
      k_next = k_val + 1'b1;
      den_in = tsc_pkg::DEN_W'(k_val) * tsc_pkg::DEN_W'(k_next);
   end

   // restoring divider, four quotient bits per cycle
   always_comb begin
      logic [tsc_pkg::DEN_W:0] trial;
      rem_in = cmd.div_first ? '0 : rem_ff;
      quo_in = cmd.div_first ? acc_ff[tsc_pkg::ACC_W-1:tsc_pkg::FRAC_W] : quo_ff;
      for (int j = 0; j < tsc_pkg::DIV_STEP; j++) begin
         trial = {rem_in, quo_in[tsc_pkg::QUO_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            trial  = trial - {1'b0, den_ff};
            quo_in = {quo_in[tsc_pkg::QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[tsc_pkg::QUO_W-2:0], 1'b0};
         end
         rem_in = trial[tsc_pkg::DEN_W-1:0];
      end
   end

   // saturated term and saturating sum
   always_comb begin
      new_mag  = (|quo_ff[tsc_pkg::QUO_W-1:tsc_pkg::MAG_W]) ? '1
                                                             : quo_ff[tsc_pkg::MAG_W-1:0];
      new_neg  = ~neg_ff;
      sum_wide = SUM_W'(sum_ff);
      mag_wide = $signed({2'b00, new_mag});
      sum_raw  = new_neg ? (sum_wide - mag_wide) : (sum_wide + mag_wide);
      if (sum_raw > SUM_MAX) begin
         new_sum = tsc_pkg::VALUE_W'(SUM_MAX);
      end else if (sum_raw < SUM_MIN) begin
         new_sum = tsc_pkg::VALUE_W'(SUM_MIN);
      end else begin
         new_sum = sum_raw[tsc_pkg::VALUE_W-1:0];
      end
   end

   always_comb begin
      count_wide = 32'(count_ff);
      terms_sat  = (count_wide > 32'd31) ? '1 : count_wide[tsc_pkg::TERMS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         capped_ff <= 1'b0;
      end else if (cmd.load) begin
         count_ff  <= '0;
         capped_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.set_capped) begin
            capped_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      if (cmd.load) begin
         ax_ff  <= abs_angle;
         mag_ff <= init_mag;
         neg_ff <= init_neg;
         sum_ff <= init_sum;
      end else if (cmd.update) begin
         mag_ff <= new_mag;
         neg_ff <= new_neg;
         sum_ff <= new_sum;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.x2_load) begin
         x2_ff <= tsc_pkg::X2_W'((prod_ff + tsc_pkg::PROD_W'(tsc_pkg::HALF_Q28))
                                 >> tsc_pkg::FRAC_W);
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.div_en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.out_load) begin
         out_value_ff  <= sum_ff;
         out_terms_ff  <= terms_sat;
         out_capped_ff <= capped_ff;
      end
   end

   assign status.ge_eps   = (mag_ff >= tsc_pkg::MAG_W'(epsilon));
   assign status.at_cap   = (count_ff >= CNT_W'(MAX_TERMS));
   assign rsp_value       = out_value_ff;
   assign rsp_terms_added = out_terms_ff;
   assign rsp_capped      = out_capped_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("term count ran past the cap");

   a_capped_at_cap: assert property (@(posedge clock) disable iff (reset)
      capped_ff |-> (count_ff == CNT_W'(MAX_TERMS)))
      else $error("capped flag set below the cap");

   a_sign_flips: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !cmd.load) |=> (neg_ff != $past(neg_ff)))
      else $error("term sign did not alternate");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_en && !cmd.div_first) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule
